[rtl/core/plr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// plr_pkg
// Shared types, constants and helpers of the pulse-length IR receiver core.
// ============================================================================
package plr_pkg;

    // Default sizing
    localparam int unsigned MaxBitsDefault   = 16;
    localparam int unsigned TickWidthDefault = 16;

    // Fixed field widths
    localparam int unsigned TickStampWidth = 16;
    localparam int unsigned MessageWidth   = 16;
    localparam int unsigned BitCountWidth  = 5;
    localparam int unsigned LengthWidth    = 8;
    localparam int unsigned CfgIndexWidth  = 3;
    localparam int unsigned CfgDataWidth   = 16;

    // Configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_ZERO_LENGTH = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_ONE_LENGTH  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_LEAD_LENGTH = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_END_LENGTH  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_TOLERANCE   = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_ACK_ENABLE  = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CFG_ACK_CODE    = 3'd6;

    // Configuration reset values
    localparam logic [LengthWidth-1:0]  ZeroLengthReset = 8'd10;
    localparam logic [LengthWidth-1:0]  OneLengthReset  = 8'd20;
    localparam logic [LengthWidth-1:0]  LeadLengthReset = 8'd40;
    localparam logic [LengthWidth-1:0]  EndLengthReset  = 8'd60;
    localparam logic [LengthWidth-1:0]  ToleranceReset  = 8'd4;
    localparam logic                    AckEnableReset  = 1'b1;
    localparam logic [MessageWidth-1:0] AckCodeReset    = 16'd1;

    // Live configuration
    typedef struct packed {
        logic [LengthWidth-1:0]  zero_length;
        logic [LengthWidth-1:0]  one_length;
        logic [LengthWidth-1:0]  lead_length;
        logic [LengthWidth-1:0]  end_length;
        logic [LengthWidth-1:0]  tolerance;
        logic                    ack_enable;
        logic [MessageWidth-1:0] ack_code;
    } plr_cfg_t;

    // Decision taken on a completed pulse
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ZERO,
        ACT_ONE,
        ACT_PREAMBLE,
        ACT_END
    } plr_action_t;

    // nominal - tol < len < nominal + tol, evaluated without wrap
    function automatic logic in_window(
        input logic [LengthWidth-1:0] len,
        input logic [LengthWidth-1:0] nominal,
        input logic [LengthWidth-1:0] tol
    );
        logic [LengthWidth:0] len_plus_tol;
        logic [LengthWidth:0] nom_plus_tol;
        len_plus_tol = {1'b0, len} + {1'b0, tol};
        nom_plus_tol = {1'b0, nominal} + {1'b0, tol};
        return (len_plus_tol > {1'b0, nominal}) && ({1'b0, len} < nom_plus_tol);
    endfunction

endpackage
`default_nettype wire

[rtl/core/pulse_length_ir_receiver_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pulse_length_ir_receiver_core
// Pulse-length IR frame receiver: edge/timeout events in, decoded frames out.
// ============================================================================
// Each accepted event lands in an input register; as it leaves that register the
// pulse is measured, classified against the four windows and the frame state
// updated, and an end marker loads the result register. A transaction is
// taken every cycle while the input side does not stall; a frame is offered
// from the result register once its end marker has moved on from the input
// register into it. The input side stalls only when an end marker
// meets a result register that is still waiting to be taken. Configuration
// writes are always taken (cfg_ready is tied high) and apply at once.
// ============================================================================
module pulse_length_ir_receiver_core
    import plr_pkg::*;
#(
    parameter int unsigned MAX_BITS   = MaxBitsDefault,
    parameter int unsigned TICK_WIDTH = TickWidthDefault
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [CfgIndexWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0]   cfg_data,
    // events
    input  wire logic                      in_valid,
    output      logic                      in_ready,
    input  wire logic                      kind,
    input  wire logic [TickStampWidth-1:0] tick_stamp,
    // frames
    output      logic                      out_valid,
    input  wire logic                      out_ready,
    output      logic [MessageWidth-1:0]   message,
    output      logic [BitCountWidth-1:0]  bit_count,
    output      logic                      preamble_seen,
    output      logic                      ack_request,
    output      logic                      is_ack,
    output      logic                      overflow
);

    localparam int unsigned HeldWidth = $clog2(MAX_BITS + 1);

    plr_cfg_t    cfg;
    plr_action_t action;

    // Tick stamp zero-extended or truncated to the counter width
    logic [TICK_WIDTH+TickStampWidth-1:0] tick_wide;
    logic [TICK_WIDTH-1:0]                tick_in;

    // Input register
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_kind_reg;
    logic [TICK_WIDTH-1:0] s1_tick_reg;

    // Frame state
    logic                  measuring_reg,     measuring_next;
    logic [TICK_WIDTH-1:0] start_tick_reg,    start_tick_next;
    logic [MAX_BITS-1:0]   bit_store_reg,     bit_store_next;
    logic [HeldWidth-1:0]  bits_held_reg,     bits_held_next;
    logic                  preamble_flag_reg, preamble_flag_next;
    logic                  overflow_flag_reg, overflow_flag_next;

    // Result register
    logic                      out_valid_reg, out_valid_next;
    logic [MessageWidth-1:0]   message_reg;
    logic [BitCountWidth-1:0]  bit_count_reg;
    logic                      preamble_seen_reg;
    logic                      ack_request_reg;
    logic                      is_ack_reg;
    logic                      overflow_reg;

    logic                               produces_result;
    logic                               s1_advance;
    logic [MAX_BITS+MessageWidth-1:0]   store_wide;
    logic [HeldWidth+BitCountWidth-1:0] held_wide;
    logic [MessageWidth-1:0]            msg_now;

    plr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plr_pulse_classify #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_pulse_classify (
        .stop_tick  (s1_tick_reg),
        .start_tick (start_tick_reg),
        .cfg        (cfg),
        .action     (action)
    );

    assign cfg_ready = 1'b1;
    assign tick_wide = {{TICK_WIDTH{1'b0}}, tick_stamp};
    assign tick_in   = tick_wide[TICK_WIDTH-1:0];

    // Stage handshake: only an end marker needs room in the result register
    assign produces_result = s1_valid_reg && !s1_kind_reg && measuring_reg
                          && (action == ACT_END);
    assign s1_advance = s1_valid_reg && (!produces_result || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
            s1_valid_next = in_valid;
    end

    // Result fields taken from the frame state
    assign store_wide = {{MessageWidth{1'b0}}, bit_store_reg};
    assign held_wide  = {{BitCountWidth{1'b0}}, bits_held_reg};
    assign msg_now    = store_wide[MessageWidth-1:0];

    // Frame state update
    always_comb
    begin
        measuring_next     = measuring_reg;
        start_tick_next    = start_tick_reg;
        bit_store_next     = bit_store_reg;
        bits_held_next     = bits_held_reg;
        preamble_flag_next = preamble_flag_reg;
        overflow_flag_next = overflow_flag_reg;
        if (s1_advance)
        begin
            if (s1_kind_reg)
            begin
                // timeout
                measuring_next     = 1'b0;
                preamble_flag_next = 1'b0;
            end
            else if (!measuring_reg)
            begin
                start_tick_next = s1_tick_reg;
                measuring_next  = 1'b1;
            end
            else
            begin
                measuring_next = 1'b0;
                case (action)
                    ACT_ZERO, ACT_ONE:
                    begin
                        if (bits_held_reg < HeldWidth'(MAX_BITS))
                        begin
                            if (action == ACT_ONE)
                                bit_store_next = bit_store_reg
                                               | (MAX_BITS'(1) << bits_held_reg);
                            bits_held_next = HeldWidth'(bits_held_reg + 1'b1);
                        end
                        else
                        begin
                            overflow_flag_next = 1'b1;
                        end
                    end
                    ACT_PREAMBLE:
                    begin
                        preamble_flag_next = 1'b1;
                        bit_store_next     = '0;
                        bits_held_next     = '0;
                        overflow_flag_next = 1'b0;
                    end
                    default:
                    begin
                        // end marker and unmatched pulses leave the frame as is
                    end
                endcase
            end
        end
    end

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_advance && produces_result)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            measuring_reg     <= 1'b0;
            start_tick_reg    <= '0;
            bit_store_reg     <= '0;
            bits_held_reg     <= '0;
            preamble_flag_reg <= 1'b0;
            overflow_flag_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            measuring_reg     <= measuring_next;
            start_tick_reg    <= start_tick_next;
            bit_store_reg     <= bit_store_next;
            bits_held_reg     <= bits_held_next;
            preamble_flag_reg <= preamble_flag_next;
            overflow_flag_reg <= overflow_flag_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg <= kind;
            s1_tick_reg <= tick_in;
        end
        if (s1_advance && produces_result)
        begin
            message_reg       <= msg_now;
            bit_count_reg     <= held_wide[BitCountWidth-1:0];
            preamble_seen_reg <= preamble_flag_reg;
            ack_request_reg   <= preamble_flag_reg && cfg.ack_enable;
            is_ack_reg        <= (msg_now == cfg.ack_code);
            overflow_reg      <= overflow_flag_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign message       = message_reg;
    assign bit_count     = bit_count_reg;
    assign preamble_seen = preamble_seen_reg;
    assign ack_request   = ack_request_reg;
    assign is_ack        = is_ack_reg;
    assign overflow      = overflow_reg;

endmodule
`default_nettype wire

[rtl/core/plr_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// plr_cfg_regs
// Configuration register file; unknown indexes are ignored.
// ============================================================================
module plr_cfg_regs
    import plr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,
    output plr_cfg_t                      cfg
);

    plr_cfg_t cfg_reg;
    plr_cfg_t cfg_next;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ZERO_LENGTH: cfg_next.zero_length = cfg_data[LengthWidth-1:0];
                CFG_ONE_LENGTH:  cfg_next.one_length  = cfg_data[LengthWidth-1:0];
                CFG_LEAD_LENGTH: cfg_next.lead_length = cfg_data[LengthWidth-1:0];
                CFG_END_LENGTH:  cfg_next.end_length  = cfg_data[LengthWidth-1:0];
                CFG_TOLERANCE:   cfg_next.tolerance   = cfg_data[LengthWidth-1:0];
                CFG_ACK_ENABLE:  cfg_next.ack_enable  = cfg_data[0];
                CFG_ACK_CODE:    cfg_next.ack_code    = cfg_data[MessageWidth-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_length <= ZeroLengthReset;
            cfg_reg.one_length  <= OneLengthReset;
            cfg_reg.lead_length <= LeadLengthReset;
            cfg_reg.end_length  <= EndLengthReset;
            cfg_reg.tolerance   <= ToleranceReset;
            cfg_reg.ack_enable  <= AckEnableReset;
            cfg_reg.ack_code    <= AckCodeReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[rtl/core/plr_pulse_classify.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// plr_pulse_classify
// Measures the pulse length from two tick stamps and picks the first window
// that it falls into.
// ============================================================================
module plr_pulse_classify
    import plr_pkg::*;
#(
    parameter int unsigned TICK_WIDTH = TickWidthDefault
)
(
    input  wire logic [TICK_WIDTH-1:0] stop_tick,
    input  wire logic [TICK_WIDTH-1:0] start_tick,
    input  wire plr_cfg_t              cfg,
    output plr_action_t                action
);

    logic [TICK_WIDTH-1:0]  tick_diff;
    logic [LengthWidth-1:0] pulse_len;

    // Length is two counts per tick, saturating once the tick difference passes 127
    assign tick_diff = stop_tick - start_tick;
    assign pulse_len = (|tick_diff[TICK_WIDTH-1:LengthWidth-1])
                     ? {LengthWidth{1'b1}}
                     : {tick_diff[LengthWidth-2:0], 1'b0};

    // Windows checked in priority order
    always_comb
    begin
        if (in_window(pulse_len, cfg.zero_length, cfg.tolerance))
            action = ACT_ZERO;
        else if (in_window(pulse_len, cfg.one_length, cfg.tolerance))
            action = ACT_ONE;
        else if (in_window(pulse_len, cfg.lead_length, cfg.tolerance))
            action = ACT_PREAMBLE;
        else if (in_window(pulse_len, cfg.end_length, cfg.tolerance))
            action = ACT_END;
        else
            action = ACT_NONE;
    end

endmodule
`default_nettype wire

[tb/tb_pulse_length_ir_receiver_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_pulse_length_ir_receiver_core
// Self-checking bench for the pulse-length IR receiver core. Edge and timeout
// events are pushed through the event channel under random bursts, while the
// frame channel stalls on its own pattern. A local decoder tracks the frame
// state and queues the frames each end marker should produce. Every delivered
// frame is compared field by field. Register settings are changed only while
// the core is idle. They range from the reset values through empty and
// full-range windows to random window layouts.
// ============================================================================
module tb_pulse_length_ir_receiver_core;
    import plr_pkg::*;

    localparam int unsigned MaxBits     = MaxBitsDefault;
    localparam int unsigned IdleLimit   = 4000;
    localparam int unsigned DrainCycles = 8;
    localparam logic [CfgIndexWidth-1:0] CfgUnusedIndex = 3'd7;

    typedef struct packed {
        logic [MessageWidth-1:0]  message;
        logic [BitCountWidth-1:0] bit_count;
        logic                     preamble_seen;
        logic                     ack_request;
        logic                     is_ack;
        logic                     overflow;
    } frame_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CfgIndexWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0]   cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      kind;
    logic [TickStampWidth-1:0] tick_stamp;
    logic                      out_valid;
    logic                      out_ready;
    logic [MessageWidth-1:0]   message;
    logic [BitCountWidth-1:0]  bit_count;
    logic                      preamble_seen;
    logic                      ack_request;
    logic                      is_ack;
    logic                      overflow;

    // Decoder state mirrored by the bench
    plr_cfg_t                  rx_cfg;
    logic                      rx_measuring;
    logic [TickStampWidth-1:0] rx_start_tick;
    logic [MessageWidth-1:0]   rx_bits;
    int unsigned               rx_bits_held;
    logic                      rx_preamble;
    logic                      rx_overflow;
    frame_t                    expected_frames[$];

    // Stimulus bookkeeping
    logic [TickStampWidth-1:0] tick_now;
    int unsigned               burst_left;
    int unsigned               idle_cycles;
    int unsigned               error_count;
    int unsigned               events_sent;
    int unsigned               timeouts_sent;
    int unsigned               frames_checked;
    int unsigned               overflow_frames;
    int unsigned               ack_frames;
    int unsigned               settings_used;

    pulse_length_ir_receiver_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .tick_stamp    (tick_stamp),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .message       (message),
        .bit_count     (bit_count),
        .preamble_seen (preamble_seen),
        .ack_request   (ack_request),
        .is_ack        (is_ack),
        .overflow      (overflow)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------------
    // Pulse length in ms: two per tick, saturating at 255
    function automatic int pulse_length(logic [TickStampWidth-1:0] diff);
        return (diff > 16'd127) ? 255 : 2 * int'(diff);
    endfunction

    // Strict window on both sides, no wrap
    function automatic logic in_win(int len, logic [LengthWidth-1:0] nominal);
        int tol;
        tol = int'(rx_cfg.tolerance);
        return (len > int'(nominal) - tol) && (len < int'(nominal) + tol);
    endfunction

    // First matching window wins
    function automatic plr_action_t classify(int len);
        if (in_win(len, rx_cfg.zero_length))
            return ACT_ZERO;
        if (in_win(len, rx_cfg.one_length))
            return ACT_ONE;
        if (in_win(len, rx_cfg.lead_length))
            return ACT_PREAMBLE;
        if (in_win(len, rx_cfg.end_length))
            return ACT_END;
        return ACT_NONE;
    endfunction

    task automatic store_bit(logic b);
        if (rx_bits_held < MaxBits)
        begin
            if (b)
                rx_bits[rx_bits_held] = 1'b1;
            rx_bits_held++;
        end
        else
            rx_overflow = 1'b1;
    endtask

    // Update decoder state for one accepted event, queue a frame on end marker
    task automatic decode_event(logic k, logic [TickStampWidth-1:0] t);
        frame_t f;
        if (k)
        begin
            rx_measuring = 1'b0;
            rx_preamble  = 1'b0;
        end
        else if (!rx_measuring)
        begin
            rx_start_tick = t;
            rx_measuring  = 1'b1;
        end
        else
        begin
            rx_measuring = 1'b0;
            case (classify(pulse_length(t - rx_start_tick)))
                ACT_ZERO:     store_bit(1'b0);
                ACT_ONE:      store_bit(1'b1);
                ACT_PREAMBLE:
                begin
                    rx_preamble  = 1'b1;
                    rx_bits      = '0;
                    rx_bits_held = 0;
                    rx_overflow  = 1'b0;
                end
                ACT_END:
                begin
                    f.message       = rx_bits;
                    f.bit_count     = rx_bits_held[BitCountWidth-1:0];
                    f.preamble_seen = rx_preamble;
                    f.ack_request   = rx_preamble && rx_cfg.ack_enable;
                    f.is_ack        = (rx_bits == rx_cfg.ack_code);
                    f.overflow      = rx_overflow;
                    expected_frames.push_back(f);
                end
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin : frame_check
        frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_frames.size() == 0)
                report_mismatch($sformatf("frame with nothing expected, message %04h", message));
            else
            begin
                want = expected_frames.pop_front();
                if (message !== want.message)
                    report_mismatch($sformatf("message %04h, expected %04h",
                                              message, want.message));
                if (bit_count !== want.bit_count)
                    report_mismatch($sformatf("bit_count %0d, expected %0d",
                                              bit_count, want.bit_count));
                if (preamble_seen !== want.preamble_seen)
                    report_mismatch($sformatf("preamble_seen %b, expected %b",
                                              preamble_seen, want.preamble_seen));
                if (ack_request !== want.ack_request)
                    report_mismatch($sformatf("ack_request %b, expected %b",
                                              ack_request, want.ack_request));
                if (is_ack !== want.is_ack)
                    report_mismatch($sformatf("is_ack %b, expected %b", is_ack, want.is_ack));
                if (overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              overflow, want.overflow));
                frames_checked++;
                if (want.overflow)
                    overflow_frames++;
                if (want.is_ack)
                    ack_frames++;
            end
        end
    end

    // Watchdog: no transaction on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d frames outstanding",
                         IdleLimit, expected_frames.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Frame channel stalls: always ready, coin toss, rotating mask, or sparse
    initial
    begin : frame_pacing
        int unsigned         mode;
        int unsigned         left;
        logic [7:0]          mask;
        left      = 0;
        mode      = 0;
        mask      = 8'hFF;
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 150);
                mask = 8'($urandom) | 8'h01;
            end
            left--;
            case (mode)
                0: out_ready = 1'b1;
                1: out_ready = 1'($urandom_range(0, 1));
                2:
                begin
                    out_ready = mask[0];
                    mask      = {mask[0], mask[7:1]};
                end
                default: out_ready = ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One event transaction; bursts of random length with random gaps
    task automatic send_event(logic k, logic [TickStampWidth-1:0] t);
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid   = 1'b1;
        kind       = k;
        tick_stamp = t;
        do @(posedge clk); while (!in_ready);
        decode_event(k, t);
        events_sent++;
        if (k)
            timeouts_sent++;
    endtask

    // Hold the event channel until all frames are out and the pipe is empty
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ZERO_LENGTH: rx_cfg.zero_length = data[LengthWidth-1:0];
            CFG_ONE_LENGTH:  rx_cfg.one_length  = data[LengthWidth-1:0];
            CFG_LEAD_LENGTH: rx_cfg.lead_length = data[LengthWidth-1:0];
            CFG_END_LENGTH:  rx_cfg.end_length  = data[LengthWidth-1:0];
            CFG_TOLERANCE:   rx_cfg.tolerance   = data[LengthWidth-1:0];
            CFG_ACK_ENABLE:  rx_cfg.ack_enable  = data[0];
            CFG_ACK_CODE:    rx_cfg.ack_code    = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Full register setting; unused upper bits carry random junk
    task automatic configure(logic [7:0] zero_len, logic [7:0] one_len, logic [7:0] pre_len,
                             logic [7:0] end_len, logic [7:0] tol, logic ack_en,
                             logic [15:0] code);
        wait_idle();
        write_reg(CFG_ZERO_LENGTH, {8'($urandom), zero_len});
        write_reg(CFG_ONE_LENGTH,  {8'($urandom), one_len});
        write_reg(CFG_LEAD_LENGTH, {8'($urandom), pre_len});
        write_reg(CFG_END_LENGTH,  {8'($urandom), end_len});
        write_reg(CFG_TOLERANCE,   {8'($urandom), tol});
        write_reg(CFG_ACK_ENABLE,  {15'($urandom), ack_en});
        write_reg(CFG_ACK_CODE,    code);
        write_reg(CfgUnusedIndex,  16'($urandom));
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Frame generation
    // ------------------------------------------------------------------------
    // Tick difference decoded as the wanted action; 128 stands for saturation
    function automatic int pick_diff(plr_action_t target);
        int hits[$];
        for (int d = 0; d <= 128; d++)
            if (classify(pulse_length(16'(d))) == target)
                hits.push_back(d);
        if (hits.size() == 0)
            return -1;
        return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    // Start and stop edge; unreachable windows fall back to a random length
    task automatic send_pulse(plr_action_t target);
        int                        d;
        logic [TickStampWidth-1:0] diff;
        d = pick_diff(target);
        if (d < 0)
            diff = 16'($urandom);
        else if (d == 128)
            diff = 16'($urandom_range(128, 65535));
        else
            diff = 16'(d);
        tick_now += 16'($urandom_range(1, 300));
        send_event(1'b0, tick_now);
        tick_now += diff;
        send_event(1'b0, tick_now);
    endtask

    task automatic send_frame();
        int unsigned       nbits;
        logic [15:0]       word;
        logic              as_ack;
        as_ack = ($urandom_range(0, 6) == 0);
        if (as_ack || $urandom_range(0, 9) != 0)
            send_pulse(ACT_PREAMBLE);
        if (as_ack)
            nbits = MaxBits;
        else if ($urandom_range(0, 4) == 0)
            nbits = $urandom_range(MaxBits + 1, MaxBits + 6);
        else
            nbits = $urandom_range(0, MaxBits);
        word = as_ack ? rx_cfg.ack_code : 16'($urandom);
        for (int i = 0; i < nbits; i++)
            send_pulse(word[i % 16] ? ACT_ONE : ACT_ZERO);
        // occasional timeout drops the preamble mark
        if ($urandom_range(0, 11) == 0)
            send_event(1'b1, 16'($urandom));
        send_pulse(ACT_END);
    endtask

    // Random edges and timeouts, then close any open measurement
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_event(($urandom_range(0, 2) == 0), 16'($urandom));
        if (rx_measuring)
            send_event(1'b0, 16'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset settings: windows zero 4..6 ticks, one 9..11, preamble 19..21, end 29..31
    task automatic test_directed_defaults();
        send_event(1'b1, 16'hFFFF);                                   // timeout from reset
        send_event(1'b0, 16'hFFF6); send_event(1'b0, 16'h000A);      // preamble across wrap
        send_event(1'b0, 16'h0100); send_event(1'b0, 16'h010A);      // one bit
        send_event(1'b0, 16'h0200); send_event(1'b0, 16'h0205);      // zero bit
        send_event(1'b0, 16'h0300); send_event(1'b0, 16'h0300);      // zero length, no window
        send_event(1'b0, 16'h0000); send_event(1'b0, 16'hFFFF);      // saturated, no window
        send_event(1'b0, 16'h0400); send_event(1'b0, 16'h041E);      // end, matches ack code
        send_event(1'b0, 16'h0500); send_event(1'b0, 16'h0507);      // just past zero window
        send_event(1'b0, 16'h0600); send_event(1'b0, 16'h061D);      // end again, state kept
        send_event(1'b1, 16'h0000);                                   // timeout clears preamble
        send_event(1'b0, 16'h0700); send_event(1'b1, 16'h0705);      // timeout mid-pulse
        send_event(1'b0, 16'h0800); send_event(1'b0, 16'h081F);      // end without preamble
    endtask

    task automatic test_random_frames(int unsigned budget);
        int unsigned stop_at;
        stop_at = events_sent + budget;
        while (events_sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_frame();
            // let the frame channel catch up completely now and then
            if ($urandom_range(0, 30) == 0)
                wait_idle();
        end
    endtask

    task automatic test_window_extremes();
        // empty windows: nothing ever decodes
        configure(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'h0000);
        test_random_frames(80);
        // widest windows: every unsaturated pulse is a zero, saturation ends
        configure(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 16'h0000);
        test_random_frames(150);
        // windows at both ends of the length range
        configure(8'd0, 8'd255, 8'd128, 8'd200, 8'd3, 1'b1, 16'hFFFF);
        test_random_frames(150);
    endtask

    task automatic test_random_settings();
        int base;
        int step;
        int tol;
        repeat (6)
        begin
            base = $urandom_range(0, 40);
            step = $urandom_range(6, 50);
            tol  = $urandom_range(1, step / 2 + 2);
            configure(8'(base),
                      8'((base + step > 255) ? 255 : base + step),
                      8'((base + 2 * step > 255) ? 255 : base + 2 * step),
                      8'((base + 3 * step > 255) ? 255 : base + 3 * step),
                      8'(tol), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15)));
            test_random_frames(135);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        kind            = 1'b0;
        tick_stamp      = '0;
        tick_now        = '0;
        burst_left      = 0;
        idle_cycles     = 0;
        error_count     = 0;
        events_sent     = 0;
        timeouts_sent   = 0;
        frames_checked  = 0;
        overflow_frames = 0;
        ack_frames      = 0;
        settings_used   = 1;
        rx_cfg          = '{ZeroLengthReset, OneLengthReset, LeadLengthReset,
                            EndLengthReset, ToleranceReset, AckEnableReset, AckCodeReset};
        rx_measuring    = 1'b0;
        rx_start_tick   = '0;
        rx_bits         = '0;
        rx_bits_held    = 0;
        rx_preamble     = 1'b0;
        rx_overflow     = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_defaults();
        test_random_frames(240);
        test_window_extremes();
        test_random_settings();

        wait_idle();
        $display("Sent %0d events (%0d timeouts) over %0d register settings",
                 events_sent, timeouts_sent, settings_used);
        $display("Checked %0d frames: %0d with dropped bits, %0d matching the ack code",
                 frames_checked, overflow_frames, ack_frames);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/core/plr_pkg.sv
rtl/core/plr_cfg_regs.sv
rtl/core/plr_pulse_classify.sv
rtl/core/pulse_length_ir_receiver_core.sv
tb/tb_pulse_length_ir_receiver_core.sv
